### design/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// Holds register indexes, reset values, the configuration bundle and the
// per-tick result bundle.
// ----------------------------------------------------------------------------
package uer_pkg;

  // Default widths of the internal counters
  localparam int CNT_W_DEF  = 20;
  localparam int ECHO_W_DEF = 16;

  // Configuration port geometry
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 3;

  // Output field widths
  localparam int DIST_W = 12;
  localparam int DUR_W  = 16;

  // Distance ceiling in tenths of a centimetre
  localparam logic [DIST_W-1:0] DIST_CAP = 12'd4000;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERVAL = 3'd0,
    REG_TIMEOUT  = 3'd1,
    REG_TRIGGER  = 3'd2,
    REG_MIN_ECHO = 3'd3,
    REG_MAX_ECHO = 3'd4
  } cfg_reg_t;

  // Register reset values
  localparam logic [19:0] INTERVAL_RST = 20'd100000;
  localparam logic [19:0] TIMEOUT_RST  = 20'd50000;
  localparam logic [7:0]  TRIGGER_RST  = 8'd10;
  localparam logic [15:0] MIN_ECHO_RST = 16'd118;
  localparam logic [15:0] MAX_ECHO_RST = 16'd23529;

  // Configuration bundle
  typedef struct packed {
    logic [19:0] interval_ticks;
    logic [19:0] timeout_ticks;
    logic [7:0]  trigger_ticks;
    logic [15:0] min_echo_ticks;
    logic [15:0] max_echo_ticks;
  } cfg_t;

  // Result bundle for one tick
  typedef struct packed {
    logic              trigger_level;
    logic [DIST_W-1:0] distance_tenths;
    logic [DUR_W-1:0]  echo_ticks;
    logic              measure_done;
    logic              timed_out;
    logic              new_result;
  } res_t;

endpackage

### design/uer_cfg_regs.sv
// ----------------------------------------------------------------------------
// uer_cfg_regs: configuration register file
// Captures writes from the plain write port; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module uer_cfg_regs
  import uer_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_INTERVAL: cfg_nxt.interval_ticks = cfg_wdata[19:0];
        REG_TIMEOUT:  cfg_nxt.timeout_ticks  = cfg_wdata[19:0];
        REG_TRIGGER:  cfg_nxt.trigger_ticks  = cfg_wdata[7:0];
        REG_MIN_ECHO: cfg_nxt.min_echo_ticks = cfg_wdata[15:0];
        REG_MAX_ECHO: cfg_nxt.max_echo_ticks = cfg_wdata[15:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold register contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interval_ticks <= INTERVAL_RST;
      cfg_r.timeout_ticks  <= TIMEOUT_RST;
      cfg_r.trigger_ticks  <= TRIGGER_RST;
      cfg_r.min_echo_ticks <= MIN_ECHO_RST;
      cfg_r.max_echo_ticks <= MAX_ECHO_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### design/uer_range_calc.sv
// ----------------------------------------------------------------------------
// uer_range_calc: echo duration to distance
// Checks the echo window and computes floor(ticks*17/100), capped, using a
// multiply by a fixed reciprocal of 100.
// ----------------------------------------------------------------------------
module uer_range_calc
  import uer_pkg::*;
#(
  parameter int ECHO_W = ECHO_W_DEF
) (
  input  logic [ECHO_W-1:0] ticks,
  input  logic [15:0]       min_echo_ticks,
  input  logic [15:0]       max_echo_ticks,
  output logic [DIST_W-1:0] distance_tenths
);

  // Compare width for the window check
  localparam int WIN_W  = (ECHO_W > 16) ? ECHO_W : 16;
  // ticks*17 width
  localparam int X_W    = ECHO_W + 5;
  // Reciprocal shift and width; error term stays below 2^SHIFT over the range
  localparam int SHIFT  = ECHO_W + 12;
  localparam int RCP_W  = SHIFT - 6;
  localparam longint unsigned RCP_L = ((64'd1 << SHIFT) + 64'd99) / 64'd100;
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_L);
  localparam int PROD_W = X_W + RCP_W;
  localparam int Q_W    = PROD_W - SHIFT;
  localparam int CMP_W  = (Q_W > DIST_W) ? Q_W : DIST_W;

  logic [WIN_W-1:0]  t_win;
  logic              in_window;
  logic [X_W-1:0]    x17;
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    quot;
  logic [CMP_W-1:0]  quot_ext;

  // Window check
  assign t_win     = WIN_W'(ticks);
  assign in_window = (t_win >= WIN_W'(min_echo_ticks)) && (t_win <= WIN_W'(max_echo_ticks));

  // ticks*17 as shift and add, then divide by 100 through the reciprocal
  assign x17      = X_W'({ticks, 4'b0000}) + X_W'(ticks);
  assign prod     = PROD_W'(x17) * PROD_W'(RCP);
  assign quot     = prod[PROD_W-1:SHIFT];
  assign quot_ext = CMP_W'(quot);

  // Cap and zero outside the window
  always_comb begin
    if (!in_window) begin
      distance_tenths = '0;
    end else if (quot_ext > CMP_W'(DIST_CAP)) begin
      distance_tenths = DIST_CAP;
    end else begin
      distance_tenths = quot_ext[DIST_W-1:0];
    end
  end

endmodule

### design/uer_tick_core.sv
// ----------------------------------------------------------------------------
// uer_tick_core: per-tick measurement sequencer
// Input register, measurement state update and result register, with a
// shared stall so a new tick enters every cycle while the output drains.
// ----------------------------------------------------------------------------
module uer_tick_core
  import uer_pkg::*;
#(
  parameter int CNT_W  = CNT_W_DEF,
  parameter int ECHO_W = ECHO_W_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_echo_level,
  output logic out_valid,
  input  logic out_ready,
  output res_t res
);

  localparam int TCMP_W = (CNT_W > 20) ? CNT_W : 20;
  localparam int DCMP_W = (ECHO_W > DUR_W) ? ECHO_W : DUR_W;

  // Pipeline control
  logic s1_valid_r, s1_valid_nxt;
  logic s1_level_r;
  logic out_valid_r, out_valid_nxt;
  logic adv;

  // Measurement state
  logic [CNT_W-1:0]  since_r, since_nxt;
  logic [ECHO_W-1:0] echo_r, echo_nxt;
  logic              prev_r, prev_nxt;
  logic              done_r, done_nxt;
  logic              tmo_r, tmo_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [DUR_W-1:0]  dur_r, dur_nxt;
  logic              fresh;
  logic              start;
  logic              trig;
  logic [DIST_W-1:0] calc_dist;
  logic [DCMP_W-1:0] t_ext;
  res_t              res_r;

  // Advance the input stage into the result register
  assign adv          = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready     = !s1_valid_r || adv;
  assign s1_valid_nxt = (in_valid && in_ready) ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Distance of the echo currently counted
  uer_range_calc #(
    .ECHO_W(ECHO_W)
  ) u_range_calc (
    .ticks          (echo_r),
    .min_echo_ticks (cfg.min_echo_ticks),
    .max_echo_ticks (cfg.max_echo_ticks),
    .distance_tenths(calc_dist)
  );

  assign start = TCMP_W'(since_r) >= TCMP_W'(cfg.interval_ticks);
  assign t_ext = DCMP_W'(echo_r);

  // Measurement state update for one tick
  always_comb begin
    since_nxt = since_r;
    echo_nxt  = echo_r;
    done_nxt  = done_r;
    tmo_nxt   = tmo_r;
    dist_nxt  = dist_r;
    dur_nxt   = dur_r;
    fresh     = 1'b0;
    prev_nxt  = s1_level_r;
    if (start) begin
      since_nxt = '0;
      done_nxt  = 1'b0;
      tmo_nxt   = 1'b0;
      echo_nxt  = ECHO_W'(s1_level_r);
    end else begin
      if (since_r != '1) begin
        since_nxt = since_r + CNT_W'(1);
      end
      if (s1_level_r) begin
        if (!prev_r) begin
          echo_nxt = ECHO_W'(1);
        end else if (echo_r != '1) begin
          echo_nxt = echo_r + ECHO_W'(1);
        end
      end else if (prev_r && !done_r) begin
        dur_nxt  = (t_ext > DCMP_W'(16'hFFFF)) ? 16'hFFFF : t_ext[DUR_W-1:0];
        dist_nxt = calc_dist;
        done_nxt = 1'b1;
        tmo_nxt  = 1'b0;
        fresh    = 1'b1;
      end
      if (!done_nxt && (TCMP_W'(since_nxt) > TCMP_W'(cfg.timeout_ticks))) begin
        done_nxt = 1'b1;
        tmo_nxt  = 1'b1;
        dist_nxt = '0;
        fresh    = 1'b1;
      end
    end
  end

  assign trig = !done_nxt && (since_nxt < CNT_W'(cfg.trigger_ticks));

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      since_r     <= '0;
      echo_r      <= '0;
      prev_r      <= 1'b0;
      done_r      <= 1'b1;
      tmo_r       <= 1'b0;
      dist_r      <= '0;
      dur_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        since_r <= since_nxt;
        echo_r  <= echo_nxt;
        prev_r  <= prev_nxt;
        done_r  <= done_nxt;
        tmo_r   <= tmo_nxt;
        dist_r  <= dist_nxt;
        dur_r   <= dur_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_level_r <= in_echo_level;
    end
    if (adv) begin
      res_r.trigger_level   <= trig;
      res_r.distance_tenths <= dist_nxt;
      res_r.echo_ticks      <= dur_nxt;
      res_r.measure_done    <= done_nxt;
      res_r.timed_out       <= tmo_nxt;
      res_r.new_result      <= fresh;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  // Checks
  a_timeout_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!res_r.timed_out || res_r.measure_done))
    else $error("timed_out without measure_done");

  a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.timed_out |-> res_r.distance_tenths == '0)
    else $error("timeout with nonzero distance");

  a_dist_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.distance_tenths <= DIST_CAP)
    else $error("distance above cap");

  a_trig_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.trigger_level |-> !res_r.measure_done)
    else $error("trigger driven on finished measurement");

  a_state_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(since_r) && $stable(done_r))
    else $error("measurement state changed without a tick");

endmodule

### design/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: ultrasonic time-of-flight ranger
// Each input transaction is one microsecond tick with the sampled echo
// level; each tick yields one result transaction with the trigger drive,
// the last distance and duration, and the measurement flags.
//
// Channels: in_* and out_* are valid/ready; cfg_* is a write-only register
// port (0 interval, 1 timeout, 2 trigger width, 3 min echo, 4 max echo).
// Path: an accepted tick passes the input register, then the result register,
// before its result appears on out_*.
// Throughput: one tick per cycle while out_ready is high; the measurement state
// update is a single pass of counter, compare and one constant multiply between the registers.
// Reset: counters clear, measure_done is set, registers take their defaults;
// the first measurement starts interval_ticks ticks after reset.
// Stall: while out_ready is low the result holds, the input register keeps
// one more tick, and in_ready drops once both are full.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int COUNTER_WIDTH = CNT_W_DEF,
  parameter int ECHO_WIDTH    = ECHO_W_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_echo_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_trigger_level,
  output logic [DIST_W-1:0]     out_distance_tenths,
  output logic [DUR_W-1:0]      out_echo_ticks,
  output logic                  out_measure_done,
  output logic                  out_timed_out,
  output logic                  out_new_result
);

  cfg_t cfg;
  res_t res;

  // Configuration registers
  uer_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  // Tick pipeline
  uer_tick_core #(
    .CNT_W (COUNTER_WIDTH),
    .ECHO_W(ECHO_WIDTH)
  ) u_tick_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_echo_level(in_echo_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .res          (res)
  );

  // Unpack the result
  assign out_trigger_level   = res.trigger_level;
  assign out_distance_tenths = res.distance_tenths;
  assign out_echo_ticks      = res.echo_ticks;
  assign out_measure_done    = res.measure_done;
  assign out_timed_out       = res.timed_out;
  assign out_new_result      = res.new_result;

endmodule
